>>> hw/rtl/priority_goal_conflict_arbiter_macros.svh
// Assertion macros for the priority goal conflict arbiter.
// Taken in by the top level with `include; no other dependencies.
`ifndef PRIORITY_GOAL_CONFLICT_ARBITER_MACROS_SVH
`define PRIORITY_GOAL_CONFLICT_ARBITER_MACROS_SVH

// same-cycle implication
`define PGCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgca assertion failed");

// next-cycle implication
`define PGCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgca assertion failed");

`endif

>>> hw/rtl/pgca_pkg.sv
`timescale 1ns / 1ps
// Package for the priority goal conflict arbiter: constants, codes and
// the structs passed between the top level and the cell row. No dependencies.
package pgca_pkg;

  // default sizes
  localparam int MAX_GOALS_DEF     = 8;
  localparam int RESOURCE_BITS_DEF = 8;
  localparam int PRIORITY_BITS_DEF = 8;

  // fixed field widths
  localparam int FIELD_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int TABLE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_TAB  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_TAB  = 2'd2;

  // opcodes
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_STOP_ALL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

  // candidate record gathered along the cell row
  typedef struct packed {
    logic               hit;
    logic               run;
    logic               use_ok;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] mask;
  } cand_t;

  // commands from the sequencer to every cell
  typedef struct packed {
    logic trim;
    logic load;
    logic stop_all;
    logic step;
    logic grant;
  } cell_ctl_t;

endpackage

>>> hw/rtl/pgca_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the arbiter: input, result and config.
// Depends on pgca_pkg for field widths.
interface pgca_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [pgca_pkg::FIELD_W-1:0]  may_continue;
  logic [pgca_pkg::FIELD_W-1:0]  may_start;

  modport source (output valid, output opcode, output may_continue, output may_start,
                  input ready);
  modport sink   (input valid, input opcode, input may_continue, input may_start,
                  output ready);
endinterface

interface pgca_out_if;
  logic                          valid;
  logic                          ready;
  logic [pgca_pkg::FIELD_W-1:0]  stopped_mask;
  logic [pgca_pkg::FIELD_W-1:0]  started_mask;
  logic [pgca_pkg::FIELD_W-1:0]  running_mask;

  modport source (output valid, output stopped_mask, output started_mask,
                  output running_mask, input ready);
  modport sink   (input valid, input stopped_mask, input started_mask,
                  input running_mask, output ready);
endinterface

interface pgca_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pgca_pkg::CFG_IDX_W-1:0]  index;
  logic [pgca_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pgca_cell.sv
`timescale 1ns / 1ps
// One goal slot of the arbiter row: holds the running, stopped and started
// bits and its visiting rank. Depends on pgca_pkg.
module pgca_cell #(
  parameter int PRIORITY_BITS = pgca_pkg::PRIORITY_BITS_DEF,
  parameter int RESOURCE_BITS = pgca_pkg::RESOURCE_BITS_DEF,
  parameter int SLOT_W        = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pgca_pkg::cell_ctl_t       ctl,
  input  logic                      active,
  input  logic                      keep,
  input  logic [PRIORITY_BITS-1:0]  prio,
  input  logic [RESOURCE_BITS-1:0]  mask,
  input  logic [SLOT_W-1:0]         rank_in,
  input  logic [SLOT_W-1:0]         pos,
  input  logic                      cont,
  input  logic                      use_in,
  input  pgca_pkg::cand_t           cand_in,
  output pgca_pkg::cand_t           cand_out,
  input  pgca_pkg::cand_t           cand_bc,
  input  logic                      blk_in,
  output logic                      blk_out,
  output logic                      sel,
  output logic                      run,
  output logic                      stopped,
  output logic                      started
);

  logic [SLOT_W-1:0]             rank_r;
  logic                          use_r;
  logic                          run_r, run_nxt;
  logic                          stop_r, stop_nxt;
  logic                          start_r, start_nxt;
  logic [pgca_pkg::FIELD_W-1:0]  prio_x;
  logic [pgca_pkg::FIELD_W-1:0]  mask_x;
  logic                          overlap;

  assign prio_x  = pgca_pkg::FIELD_W'(prio);
  assign mask_x  = pgca_pkg::FIELD_W'(mask);
  assign sel     = active && (rank_r == pos);
  assign overlap = |(mask_x & cand_bc.mask);

  // forward pass: the selected cell drops its record into the chain
  always_comb begin
    cand_out = cand_in;
    if (sel) begin
      cand_out.hit    = 1'b1;
      cand_out.run    = run_r;
      cand_out.use_ok = use_r;
      cand_out.prio   = prio_x;
      cand_out.mask   = mask_x;
    end
  end

  // second pass: a running, overlapping goal of no worse priority blocks
  assign blk_out = blk_in || (run_r && overlap && (prio_x <= cand_bc.prio));

  // slot state update
  always_comb begin
    run_nxt   = run_r;
    stop_nxt  = stop_r;
    start_nxt = start_r;
    if (ctl.trim && !keep) begin
      run_nxt = 1'b0;
    end
    if (ctl.load) begin
      start_nxt = 1'b0;
      if (ctl.stop_all) begin
        stop_nxt = run_r && active;
        run_nxt  = 1'b0;
      end else begin
        stop_nxt = run_r && active && !cont;
        run_nxt  = run_r && active && cont;
      end
    end
    if (ctl.step && ctl.grant) begin
      if (sel) begin
        run_nxt   = 1'b1;
        start_nxt = 1'b1;
      end else if (run_r && overlap) begin
        run_nxt  = 1'b0;
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      stop_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      stop_r  <= stop_nxt;
      start_r <= start_nxt;
    end
  end

  // rank follows config; start permission captured with the word
  always_ff @(posedge clk) begin
    rank_r <= rank_in;
    if (ctl.load) begin
      use_r <= use_in;
    end
  end

  assign run     = run_r;
  assign stopped = stop_r;
  assign started = start_r;

endmodule

>>> hw/rtl/priority_goal_conflict_arbiter.sv
`timescale 1ns / 1ps
// Top level of the priority goal conflict arbiter: config registers, rank
// logic, sequencer and the row of pgca_cell. Depends on pgca_pkg, pgca_if, pgca_cell and the macros file.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   opcode, may_continue, may_start
//   out_ch   out  valid/ready   stopped_mask, started_mask, running_mask
//   cfg_ch   in   valid/ready   index, data (always ready)
//
// A tick word first applies the continue masks, then walks the candidate
// through the cell row, slot by slot in priority order, and then loads the
// output register. A stop-all word, or a tick with no slot in use, skips the walk.
// Synchronous active-low reset clears the running bits and config registers.
// A new word is taken only once the previous result sits in the output
// register; a stalled output holds the sequencer in its final state.
module priority_goal_conflict_arbiter #(
  parameter int MAX_GOALS     = pgca_pkg::MAX_GOALS_DEF,
  parameter int RESOURCE_BITS = pgca_pkg::RESOURCE_BITS_DEF,
  parameter int PRIORITY_BITS = pgca_pkg::PRIORITY_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pgca_in_if.sink     in_ch,
  pgca_out_if.source  out_ch,
  pgca_cfg_if.sink    cfg_ch
);

  `include "priority_goal_conflict_arbiter_macros.svh"

  localparam int SLOT_W = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
  localparam int CNT_W  = $clog2(MAX_GOALS + 1);

  // config registers
  logic [pgca_pkg::COUNT_W-1:0] gc_r;
  logic [pgca_pkg::TABLE_W-1:0] prio_tab_r;
  logic [pgca_pkg::TABLE_W-1:0] res_tab_r;

  logic                 cfg_fire;
  logic                 trim;
  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     n_new;
  logic [pgca_pkg::COUNT_W-1:0] gc_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign trim         = cfg_fire && (cfg_ch.index == pgca_pkg::REG_GOAL_COUNT);
  assign gc_wr        = cfg_ch.data[pgca_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r       <= '0;
      prio_tab_r <= '0;
      res_tab_r  <= '0;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        pgca_pkg::REG_GOAL_COUNT:   gc_r       <= gc_wr;
        pgca_pkg::REG_PRIORITY_TAB: prio_tab_r <= cfg_ch.data;
        pgca_pkg::REG_RESOURCE_TAB: res_tab_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // count clamped to the slot count
  assign n_act = (gc_r > pgca_pkg::COUNT_W'(MAX_GOALS)) ? CNT_W'(MAX_GOALS)
                                                         : gc_r[CNT_W-1:0];
  assign n_new = (gc_wr > pgca_pkg::COUNT_W'(MAX_GOALS)) ? CNT_W'(MAX_GOALS)
                                                          : gc_wr[CNT_W-1:0];

  // per-slot views of the tables
  logic [MAX_GOALS-1:0]     active;
  logic [MAX_GOALS-1:0]     keep;
  logic [PRIORITY_BITS-1:0] prio [MAX_GOALS];
  logic [RESOURCE_BITS-1:0] mask [MAX_GOALS];
  logic [SLOT_W-1:0]        rank [MAX_GOALS];

  for (genvar s = 0; s < MAX_GOALS; s++) begin : g_slot
    logic [MAX_GOALS-1:0] ahead;
    assign active[s] = CNT_W'(s) < n_act;
    assign keep[s]   = CNT_W'(s) < n_new;
    assign prio[s]   = prio_tab_r[pgca_pkg::FIELD_W*s +: PRIORITY_BITS];
    assign mask[s]   = res_tab_r[pgca_pkg::FIELD_W*s +: RESOURCE_BITS];
    // visiting rank: slots in use ordered ahead of this one
    always_comb begin
      for (int k = 0; k < MAX_GOALS; k++) begin
        ahead[k] = active[k] && ((prio[k] < prio[s]) || ((prio[k] == prio[s]) && (k < s)));
      end
    end
    assign rank[s] = SLOT_W'($countones(ahead));
  end

  // sequencer
  pgca_pkg::state_t    state_r, state_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  pgca_pkg::cell_ctl_t ctl;
  logic                in_fire;
  logic                out_free;
  logic                last_pos;
  logic                grant;
  logic                out_valid_r;

  assign in_ch.ready = (state_r == pgca_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_pos    = (pos_r == SLOT_W'(n_act - CNT_W'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgca_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((in_ch.opcode == pgca_pkg::OP_STOP_ALL) || (n_act == '0)) begin
            state_nxt = pgca_pkg::ST_DONE;
          end else begin
            state_nxt = pgca_pkg::ST_STEP;
          end
        end
      end
      pgca_pkg::ST_STEP: begin
        if (last_pos) begin
          state_nxt = pgca_pkg::ST_DONE;
        end
      end
      pgca_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pgca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgca_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl          = '0;
    ctl.trim     = trim;
    ctl.stop_all = (in_ch.opcode == pgca_pkg::OP_STOP_ALL);
    ctl.grant    = grant;
    pos_nxt      = pos_r;
    case (state_r)
      pgca_pkg::ST_IDLE: begin
        ctl.load = in_fire;
        pos_nxt  = '0;
      end
      pgca_pkg::ST_STEP: begin
        ctl.step = 1'b1;
        pos_nxt  = pos_r + SLOT_W'(1);
      end
      pgca_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgca_pkg::ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // cell row
  pgca_pkg::cand_t      cand_chain [MAX_GOALS+1];
  logic [MAX_GOALS:0]   blk_chain;
  pgca_pkg::cand_t      cand_bc;
  logic [MAX_GOALS-1:0] sel_vec;
  logic [MAX_GOALS-1:0] run_vec;
  logic [MAX_GOALS-1:0] stop_vec;
  logic [MAX_GOALS-1:0] start_vec;

  assign cand_chain[0] = '0;
  assign blk_chain[0]  = 1'b0;
  assign cand_bc       = cand_chain[MAX_GOALS];
  assign grant         = cand_bc.hit && !cand_bc.run && cand_bc.use_ok
                         && !blk_chain[MAX_GOALS];

  for (genvar s = 0; s < MAX_GOALS; s++) begin : g_cell
    pgca_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .RESOURCE_BITS (RESOURCE_BITS),
      .SLOT_W        (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .active   (active[s]),
      .keep     (keep[s]),
      .prio     (prio[s]),
      .mask     (mask[s]),
      .rank_in  (rank[s]),
      .pos      (pos_r),
      .cont     (in_ch.may_continue[s]),
      .use_in   (in_ch.may_start[s]),
      .cand_in  (cand_chain[s]),
      .cand_out (cand_chain[s+1]),
      .cand_bc  (cand_bc),
      .blk_in   (blk_chain[s]),
      .blk_out  (blk_chain[s+1]),
      .sel      (sel_vec[s]),
      .run      (run_vec[s]),
      .stopped  (stop_vec[s]),
      .started  (start_vec[s])
    );
  end

  // output register
  logic [pgca_pkg::FIELD_W-1:0] stop_out_r;
  logic [pgca_pkg::FIELD_W-1:0] start_out_r;
  logic [pgca_pkg::FIELD_W-1:0] run_out_r;
  logic                         out_load;

  assign out_load = (state_r == pgca_pkg::ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      stop_out_r  <= pgca_pkg::FIELD_W'(stop_vec);
      start_out_r <= pgca_pkg::FIELD_W'(start_vec);
      run_out_r   <= pgca_pkg::FIELD_W'(run_vec);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.stopped_mask = stop_out_r;
  assign out_ch.started_mask = start_out_r;
  assign out_ch.running_mask = run_out_r;

  // checks; ranks are registered from the config registers, so the one-hot
  // check only applies while the row is being walked
  `PGCA_ASSERT_IMPL(a_started_still_run, clk, rst_n, out_valid_r, (start_out_r & ~run_out_r) == '0)
  `PGCA_ASSERT_IMPL(a_one_candidate, clk, rst_n, state_r == pgca_pkg::ST_STEP, $onehot0(sel_vec))
  `PGCA_ASSERT_IMPL(a_step_has_cand, clk, rst_n, state_r == pgca_pkg::ST_STEP, cand_bc.hit)
  `PGCA_ASSERT_NEXT(a_result_shown, clk, rst_n, out_load, out_valid_r)

endmodule

>>> dv/priority_goal_conflict_arbiter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for priority_goal_conflict_arbiter: drives tick and
// stop-all words, predicts stopped/started/running masks and checks each result.
// Depends on pgca_pkg, pgca_if and the arbiter RTL.
module priority_goal_conflict_arbiter_tb;

  typedef struct packed {
    logic [pgca_pkg::FIELD_W-1:0] stopped;
    logic [pgca_pkg::FIELD_W-1:0] started;
    logic [pgca_pkg::FIELD_W-1:0] running;
  } goal_masks_t;

  localparam int PHASE_WORDS = 100;
  localparam int NUM_PHASES  = 12;

  // index with no register behind it
  localparam logic [pgca_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  pgca_in_if  in_ch();
  pgca_out_if out_ch();
  pgca_cfg_if cfg_ch();

  priority_goal_conflict_arbiter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the block's registers and running bits
  logic [pgca_pkg::COUNT_W-1:0] goal_cnt;
  logic [pgca_pkg::TABLE_W-1:0] prio_tab;
  logic [pgca_pkg::TABLE_W-1:0] res_tab;
  logic [pgca_pkg::FIELD_W-1:0] running_bits;

  goal_masks_t pending_masks[$];
  int          error_count;
  bit          burst_mode;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    return burst_mode ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] slot_prio(input int s);
    return prio_tab[8*s +: 8];
  endfunction

  function automatic logic [7:0] slot_res(input int s);
    return res_tab[8*s +: 8];
  endfunction

  function automatic logic [7:0] active_slots();
    logic [8:0] ones;
    int         n;
    n    = (goal_cnt > 4'd8) ? 8 : int'(goal_cnt);
    ones = (9'd1 << n) - 9'd1;
    return ones[7:0];
  endfunction

  // predicted outcome of one word; updates the shadow running bits
  function automatic goal_masks_t arbitrate_goals(input logic op,
                                                  input logic [7:0] cont,
                                                  input logic [7:0] start);
    goal_masks_t res;
    int          n;
    int          order[8];
    int          i, j, k, c;
    logic        ok;
    logic [7:0]  run, stopped, started, cres;
    n       = (goal_cnt > 4'd8) ? 8 : int'(goal_cnt);
    run     = running_bits & active_slots();
    stopped = '0;
    started = '0;
    if (op == pgca_pkg::OP_STOP_ALL) begin
      stopped = run;
      run     = '0;
    end else begin
      stopped = run & ~cont;
      run     = run & cont;
      // stable ascending priority order
      for (i = 0; i < n; i++) begin
        j = i;
        while (j > 0 && slot_prio(order[j-1]) > slot_prio(i)) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (i = 0; i < n; i++) begin
        c = order[i];
        if (run[c]) continue;
        cres = slot_res(c);
        ok   = 1'b1;
        for (k = 0; k < n; k++)
          if (run[k] && (slot_res(k) & cres) != 0 && slot_prio(k) <= slot_prio(c))
            ok = 1'b0;
        if (!ok || !start[c]) continue;
        // preempt every overlapping running goal
        for (k = 0; k < n; k++)
          if (run[k] && (slot_res(k) & cres) != 0) begin
            run[k]     = 1'b0;
            stopped[k] = 1'b1;
          end
        run[c]     = 1'b1;
        started[c] = 1'b1;
      end
    end
    running_bits = run;
    res.stopped  = stopped;
    res.started  = started;
    res.running  = run;
    return res;
  endfunction

  // send one word, leaving valid high for a back-to-back successor
  task automatic send_word(input logic op, input logic [7:0] cont,
                           input logic [7:0] start);
    int          gap;
    goal_masks_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.may_continue <= cont;
    in_ch.may_start    <= start;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pred          = arbitrate_goals(op, cont, start);
    pending_masks = {pending_masks, pred};
  endtask

  task automatic tick(input logic [7:0] cont, input logic [7:0] start);
    send_word(pgca_pkg::OP_TICK, cont, start);
  endtask

  task automatic stop_all();
    send_word(pgca_pkg::OP_STOP_ALL, 8'($urandom), 8'($urandom));
  endtask

  // block is idle once every pending result has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pgca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    case (idx)
      pgca_pkg::REG_GOAL_COUNT: begin
        goal_cnt     = data[pgca_pkg::COUNT_W-1:0];
        running_bits = running_bits & active_slots();
      end
      pgca_pkg::REG_PRIORITY_TAB: prio_tab = data;
      pgca_pkg::REG_RESOURCE_TAB: res_tab  = data;
      default: ;
    endcase
  endtask

  // result side: random stalls, compare against oldest prediction
  initial begin
    goal_masks_t exp_m;
    int          stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (pending_masks.size() == 0) begin
        report_error("result word with nothing pending");
      end else begin
        exp_m = pending_masks.pop_front();
        if (out_ch.stopped_mask !== exp_m.stopped)
          report_error($sformatf("stopped_mask expected %02h got %02h",
                                 exp_m.stopped, out_ch.stopped_mask));
        if (out_ch.started_mask !== exp_m.started)
          report_error($sformatf("started_mask expected %02h got %02h",
                                 exp_m.started, out_ch.started_mask));
        if (out_ch.running_mask !== exp_m.running)
          report_error($sformatf("running_mask expected %02h got %02h",
                                 exp_m.running, out_ch.running_mask));
      end
    end
  end

  // nothing in use straight after reset
  task automatic test_after_reset();
    tick(8'hFF, 8'hFF);
    tick(8'h00, 8'h00);
    stop_all();
  endtask

  // distinct priorities, overlapping and empty masks, stop and restart
  task automatic test_basic_arbitration();
    write_reg(pgca_pkg::REG_PRIORITY_TAB, 64'h0706050403020100);
    write_reg(pgca_pkg::REG_RESOURCE_TAB, 64'hC04080FF00030201);
    write_reg(pgca_pkg::REG_GOAL_COUNT, 64'd8);
    tick(8'hFF, 8'hFF);
    tick(8'hFF, 8'hFF);
    tick(8'h00, 8'hFF);
    tick(8'hFF, 8'h00);
    tick(8'hAA, 8'h55);
    stop_all();
    tick(8'h00, 8'h00);
    tick(8'hFF, 8'h08);
    tick(8'hFF, 8'hF7);
  endtask

  // ties keep slot order; extreme priority values
  task automatic test_equal_priorities();
    write_reg(pgca_pkg::REG_PRIORITY_TAB, 64'h0);
    write_reg(pgca_pkg::REG_RESOURCE_TAB, 64'hFFFFFFFFFFFFFFFF);
    tick(8'hFF, 8'hFF);
    tick(8'h00, 8'hFE);
    write_reg(pgca_pkg::REG_PRIORITY_TAB, 64'hFFFFFFFFFFFFFFFF);
    tick(8'hFF, 8'hFF);
    write_reg(pgca_pkg::REG_PRIORITY_TAB, 64'h00FF00FF00FF00FF);
    tick(8'hFF, 8'hFF);
    stop_all();
  endtask

  // oversized count, shrinking count clears running bits, unknown index
  task automatic test_count_limits();
    write_reg(pgca_pkg::REG_RESOURCE_TAB, 64'h8040201008040201);
    write_reg(pgca_pkg::REG_GOAL_COUNT, 64'hF);
    tick(8'hFF, 8'hFF);
    write_reg(pgca_pkg::REG_GOAL_COUNT, 64'd3);
    tick(8'hFF, 8'hFF);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    tick(8'hFF, 8'h00);
    write_reg(pgca_pkg::REG_GOAL_COUNT, 64'd0);
    tick(8'hFF, 8'hFF);
  endtask

  // random phases over several register settings
  task automatic test_random_traffic();
    int          phase, w, b;
    logic [63:0] prio_v, res_v, cnt_v;
    logic [7:0]  cont, start;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       cnt_v = 64'd8;
        1:       cnt_v = 64'd15;
        2:       cnt_v = 64'd1;
        default: cnt_v = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 15))
                                                     : 64'($urandom_range(5, 8));
      endcase
      for (b = 0; b < 8; b++) begin
        prio_v[8*b +: 8] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom);
        case ($urandom_range(0, 2))
          0:       res_v[8*b +: 8] = 8'd1 << $urandom_range(0, 7);
          1:       res_v[8*b +: 8] = 8'($urandom & $urandom);
          default: res_v[8*b +: 8] = 8'($urandom);
        endcase
      end
      if (phase == 3) prio_v = '0;
      if (phase == 4) prio_v = '1;
      if (phase == 5) res_v = '1;
      if (phase == 6) res_v = '0;
      write_reg(pgca_pkg::REG_PRIORITY_TAB, prio_v);
      write_reg(pgca_pkg::REG_RESOURCE_TAB, res_v);
      write_reg(pgca_pkg::REG_GOAL_COUNT, cnt_v);
      if (phase == 7) write_reg(REG_UNUSED, {$urandom, $urandom});
      burst_mode = (phase % 4 == 2);
      for (w = 0; w < PHASE_WORDS; w++) begin
        if ($urandom_range(0, 9) == 0) begin
          stop_all();
        end else begin
          // mostly let goals continue so that preemption gets exercised
          cont  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom | $urandom);
          start = 8'($urandom);
          tick(cont, start);
        end
      end
      burst_mode = 1'b0;
    end
  endtask

  // main sequence
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= pgca_pkg::OP_TICK;
    in_ch.may_continue <= '0;
    in_ch.may_start    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= pgca_pkg::REG_GOAL_COUNT;
    cfg_ch.data        <= '0;
    goal_cnt     = '0;
    prio_tab     = '0;
    res_tab      = '0;
    running_bits = '0;
    error_count  = 0;
    burst_mode   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_basic_arbitration();
    test_equal_priorities();
    test_count_limits();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pgca_pkg.sv
hw/rtl/pgca_if.sv
hw/rtl/pgca_cell.sv
hw/rtl/priority_goal_conflict_arbiter.sv
dv/priority_goal_conflict_arbiter_tb.sv
